// ----- sv/ring_cached_free_block_allocator_assert.svh -----
// assertion macros used by the allocator rtl
`ifndef RING_CACHED_FREE_BLOCK_ALLOCATOR_ASSERT_SVH
`define RING_CACHED_FREE_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked at every clock edge out of reset
`define RCFBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication
`define RCFBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ----- sv/rcfba_pkg.sv -----
// ----------------------------------------------------------------------------
// rcfba_pkg
// types and codes shared by the block-id allocator modules
// ----------------------------------------------------------------------------
`default_nettype none

package rcfba_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FETCH,
    ST_EMIT
  } rcfba_state_e;

  typedef enum logic [1:0] {
    SRC_RING  = 2'd0,
    SRC_LIST  = 2'd1,
    SRC_FRESH = 2'd2,
    SRC_NONE  = 2'd3
  } rcfba_src_e;

  typedef enum logic {
    KIND_REQ = 1'b0,
    KIND_REL = 1'b1
  } rcfba_kind_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] block_id;
  } rcfba_in_t;

  typedef struct packed {
    logic [15:0] granted_id;
    logic [1:0]  source;
    logic [16:0] free_total;
    logic        out_of_space;
  } rcfba_out_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic need_read;
    logic out_free;
  } rcfba_stat_t;

  // sequencer strobes to the datapath
  typedef struct packed {
    logic         take;
    logic         issue;
    logic         fetch;
    logic         load;
    rcfba_state_e state;
  } rcfba_ctl_t;

endpackage

`default_nettype wire

// ----- sv/rcfba_ram.sv -----
// ----------------------------------------------------------------------------
// rcfba_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rcfba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/rcfba_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcfba_ctrl
// per-item sequencer: take, issue, memory fetch, emit
// ----------------------------------------------------------------------------
`default_nettype none

module rcfba_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire rcfba_pkg::rcfba_stat_t stat_i,
  output logic                      in_stall_o,
  output rcfba_pkg::rcfba_ctl_t     ctl_o
);

  import rcfba_pkg::*;

  rcfba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctl_o.take  = 1'b0;
    ctl_o.issue = 1'b0;
    ctl_o.fetch = 1'b0;
    ctl_o.load  = 1'b0;
    ctl_o.state = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.take = 1'b1;
          state_d    = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        ctl_o.issue = 1'b1;
        state_d     = stat_i.need_read ? ST_FETCH : ST_EMIT;
      end
      ST_FETCH: begin
        ctl_o.fetch = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          ctl_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ----- sv/ring_cached_free_block_allocator.sv -----
// sequence: a release or a fresh/failed request goes through the issue and emit steps before
//   out_valid rises; a ring or list pop adds a fetch step for the registered ram read
// flow: a new item is taken only in idle, after the previous result is loaded into the
//   one-deep output register; output stall stretches the emit step
// reset: asynchronous, active low; clears counters, pointers and handshake state;
//   ring and link rams are not cleared and are only read where written before
// ----------------------------------------------------------------------------
// ring_cached_free_block_allocator
// block-id allocator: fifo ring cache of freed ids, overflow lifo list linked
// through a per-id next-pointer ram, fresh ids from a saturating block count
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_cached_free_block_allocator_assert.svh"

module ring_cached_free_block_allocator #(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned ID_BITS    = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire rcfba_pkg::rcfba_in_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output rcfba_pkg::rcfba_out_t      out_data_o
);

  import rcfba_pkg::*;

  // stored ids never exceed the 16-bit input field
  localparam int unsigned IdW   = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int unsigned HeadW = $clog2(RING_DEPTH);
  localparam int unsigned FillW = HeadW + 1;
  localparam int unsigned FreeW = ID_BITS + 1;
  localparam int unsigned CmpW  = (FillW > FreeW) ? FillW : FreeW;

  // sequencer
  rcfba_stat_t stat;
  rcfba_ctl_t  ctl;

  rcfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  // allocator state
  logic [HeadW-1:0] ring_head_q, ring_head_d;
  logic [FillW-1:0] ring_fill_q, ring_fill_d;
  logic [IdW-1:0]   list_top_q, list_top_d;
  logic [FreeW-1:0] free_count_q, free_count_d;
  logic [FreeW-1:0] block_count_q, block_count_d;

  // held item and pending result
  logic             item_kind_q;
  logic [IdW-1:0]   item_id_q;
  logic [15:0]      res_id_q, res_id_d;
  rcfba_src_e       res_src_q, res_src_d;
  logic             res_oos_q, res_oos_d;

  // output register
  logic             out_valid_q;
  rcfba_out_t       out_q;

  // ram ports
  logic             ring_we;
  logic [HeadW-1:0] ring_addr;
  logic [IdW-1:0]   ring_wdata;
  logic [IdW-1:0]   ring_rdata;
  logic             link_we;
  logic [IdW-1:0]   link_addr;
  logic [IdW-1:0]   link_wdata;
  logic [IdW-1:0]   link_rdata;

  rcfba_ram #(
    .WIDTH (IdW),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .addr_i  (ring_addr),
    .wdata_i (ring_wdata),
    .rdata_o (ring_rdata)
  );

  rcfba_ram #(
    .WIDTH (IdW),
    .DEPTH (2 ** IdW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .addr_i  (link_addr),
    .wdata_i (link_wdata),
    .rdata_o (link_rdata)
  );

  // status decode
  logic             is_req;
  logic             ring_nonempty;
  logic             ring_full;
  logic             list_nonempty;
  logic             fresh_avail;
  logic             store_full;
  logic [HeadW:0]   tail_sum;
  logic [HeadW-1:0] tail_idx;
  logic [HeadW-1:0] head_next;
  logic [32:0]      fresh_wide;
  logic [32:0]      free_wide;

  assign is_req        = (item_kind_q == KIND_REQ);
  assign ring_nonempty = (ring_fill_q != '0);
  assign ring_full     = (ring_fill_q == FillW'(RING_DEPTH));
  // list length is free count minus ring fill
  assign list_nonempty = (CmpW'(free_count_q) > CmpW'(ring_fill_q));
  // block count and free count saturate at the full id space
  assign fresh_avail   = !block_count_q[ID_BITS];
  assign store_full    = free_count_q[ID_BITS];

  // tail slot: (head + fill) mod depth, fill below depth when used
  assign tail_sum  = (HeadW + 1)'(ring_head_q) + (HeadW + 1)'(ring_fill_q);
  assign tail_idx  = (tail_sum >= (HeadW + 1)'(RING_DEPTH))
                   ? HeadW'(tail_sum - (HeadW + 1)'(RING_DEPTH))
                   : HeadW'(tail_sum);
  assign head_next = (ring_head_q == HeadW'(RING_DEPTH - 1))
                   ? '0 : ring_head_q + HeadW'(1);

  assign fresh_wide = 33'(block_count_q);
  assign free_wide  = 33'(free_count_q);

  assign stat.need_read = is_req && (ring_nonempty || list_nonempty);
  assign stat.out_free  = !out_valid_q || !out_stall_i;

  // issue step: decide the source, do writes and reads; fetch step: consume read data
  always_comb begin
    ring_head_d   = ring_head_q;
    ring_fill_d   = ring_fill_q;
    list_top_d    = list_top_q;
    free_count_d  = free_count_q;
    block_count_d = block_count_q;
    res_id_d      = res_id_q;
    res_src_d     = res_src_q;
    res_oos_d     = res_oos_q;
    ring_we       = 1'b0;
    ring_addr     = ring_head_q;
    ring_wdata    = item_id_q;
    link_we       = 1'b0;
    link_addr     = list_top_q;
    link_wdata    = list_nonempty ? list_top_q : '0;

    if (ctl.issue) begin
      res_id_d  = '0;
      res_src_d = SRC_NONE;
      res_oos_d = 1'b0;
      if (is_req) begin
        if (ring_nonempty) begin
          // read oldest ring entry
          res_src_d = SRC_RING;
        end else if (list_nonempty) begin
          // read link of list head
          res_src_d = SRC_LIST;
        end else if (fresh_avail) begin
          res_src_d     = SRC_FRESH;
          res_id_d      = fresh_wide[15:0];
          block_count_d = block_count_q + FreeW'(1);
        end else begin
          res_oos_d = 1'b1;
        end
      end else if (store_full) begin
        // free store full: release dropped
        res_oos_d = 1'b1;
      end else if (!ring_full) begin
        ring_we      = 1'b1;
        ring_addr    = tail_idx;
        ring_fill_d  = ring_fill_q + FillW'(1);
        free_count_d = free_count_q + FreeW'(1);
      end else begin
        // ring full: push onto overflow list
        link_we      = 1'b1;
        link_addr    = item_id_q;
        list_top_d   = item_id_q;
        free_count_d = free_count_q + FreeW'(1);
      end
    end

    if (ctl.fetch) begin
      free_count_d = free_count_q - FreeW'(1);
      if (res_src_q == SRC_RING) begin
        res_id_d    = 16'(ring_rdata);
        ring_head_d = head_next;
        ring_fill_d = ring_fill_q - FillW'(1);
      end else begin
        res_id_d   = 16'(list_top_q);
        list_top_d = link_rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_head_q   <= '0;
      ring_fill_q   <= '0;
      list_top_q    <= '0;
      free_count_q  <= '0;
      block_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      ring_head_q   <= ring_head_d;
      ring_fill_q   <= ring_fill_d;
      list_top_q    <= list_top_d;
      free_count_q  <= free_count_d;
      block_count_q <= block_count_d;
      if (ctl.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl.take) begin
      item_kind_q <= in_data_i.kind;
      item_id_q   <= in_data_i.block_id[IdW-1:0];
    end
    res_id_q  <= res_id_d;
    res_src_q <= res_src_d;
    res_oos_q <= res_oos_d;
    if (ctl.load) begin
      out_q.granted_id   <= res_id_q;
      out_q.source       <= res_src_q;
      out_q.free_total   <= free_wide[16:0];
      out_q.out_of_space <= res_oos_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `RCFBA_ASSERT_NOW(a_ring_fill_bound, 1'b1, ring_fill_q <= FillW'(RING_DEPTH))
  `RCFBA_ASSERT_NOW(a_ring_within_free, 1'b1, CmpW'(ring_fill_q) <= CmpW'(free_count_q))
  `RCFBA_ASSERT_NOW(a_load_into_free_slot, ctl.load, !out_valid_q || !out_stall_i)
  `RCFBA_ASSERT_NEXT(a_take_goes_busy, in_valid_i && !in_stall_o, ctl.state == ST_ISSUE)

endmodule

`default_nettype wire
